// File: rtl/ternary_max_heap_queue_core_assert.svh
// assertion macros for the heap queue core
`ifndef TERNARY_MAX_HEAP_QUEUE_CORE_ASSERT_SVH
`define TERNARY_MAX_HEAP_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define TMHQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");

// next-cycle implication
`define TMHQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`endif

// File: rtl/tmhq_pkg.sv
`default_nettype none
package tmhq_pkg;

   localparam int CAPACITY_DEF = 128;

   localparam logic [2:0] FN_INSERT = 3'd0;
   localparam logic [2:0] FN_REMOVE = 3'd1;
   localparam logic [2:0] FN_CHANGE = 3'd2;
   localparam logic [2:0] FN_LOOKUP = 3'd3;
   localparam logic [2:0] FN_MIN    = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [15:0] key;
      logic [7:0]  pri;
   } entry_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  count;
      logic [15:0] top_key;
      logic [7:0]  top_priority;
      logic [7:0]  found_position;
      logic [7:0]  found_priority;
      logic [15:0] min_key;
      logic [7:0]  min_priority;
   } result_type;

endpackage
`default_nettype wire

// File: rtl/tmhq_store.sv
`default_nettype none
module tmhq_store
   import tmhq_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int AW    = $clog2(CAPACITY_DEF)
) (
   input  wire logic      clock,
   input  wire logic      wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type      rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/tmhq_seq.sv
`default_nettype none
module tmhq_seq
   import tmhq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int AW       = $clog2(CAPACITY_DEF),
   parameter int CW       = $clog2(CAPACITY_DEF + 1)
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [2:0] func,
   input  wire entry_type  entry,
   output logic            idle,
   input  wire logic       out_free,
   output logic            done,
   output result_type      result,
   output logic            wr_en,
   output logic [AW-1:0]   wr_addr,
   output entry_type       wr_data,
   output logic [AW-1:0]   rd_addr,
   input  wire entry_type  rd_data
);

   localparam int CHW = AW + 2;

   typedef enum logic [16:0] {
      S_IDLE   = 17'h00001,
      S_INS    = 17'h00002,
      S_PCALC  = 17'h00004,
      S_SD_RD  = 17'h00008,
      S_SD_LD  = 17'h00010,
      S_SD_CH  = 17'h00020,
      S_SD_CMP = 17'h00040,
      S_SWAP0  = 17'h00080,
      S_SWAP1  = 17'h00100,
      S_RM_RD  = 17'h00200,
      S_RM_WR  = 17'h00400,
      S_SC_RD  = 17'h00800,
      S_SC_CMP = 17'h01000,
      S_CP_RD  = 17'h02000,
      S_CP_WR  = 17'h04000,
      S_TOP_RD = 17'h08000,
      S_FIN    = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] func_ff, func_in;
   entry_type ent_ff, ent_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] hit_ff, hit_in;
   logic found_ff, found_in;
   logic [1:0] status_ff, status_in;
   logic [7:0] fpos_ff, fpos_in;
   logic [7:0] fpri_ff, fpri_in;
   entry_type min_ff, min_in;
   logic [AW-1:0] p_ff, p_in;
   logic [CW:0] t_ff, t_in;
   logic [AW-1:0] si_ff, si_in;
   logic [AW-1:0] best_ff, best_in;
   entry_type bval_ff, bval_in;
   entry_type cur_ff, cur_in;
   logic [AW-1:0] c_ff, c_in;
   logic [1:0] k_ff, k_in;
   logic reb_ff, reb_in;

   logic [CHW-1:0] child;
   logic scan_last;

   assign child = (CHW'(si_ff) << 1) + CHW'(si_ff) + CHW'(3) - CHW'(k_ff);
   assign scan_last = (CW'(idx_ff) + CW'(1)) == cnt_ff;
   assign idle = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      ent_in    = ent_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      found_in  = found_ff;
      status_in = status_ff;
      fpos_in   = fpos_ff;
      fpri_in   = fpri_ff;
      min_in    = min_ff;
      p_in      = p_ff;
      t_in      = t_ff;
      si_in     = si_ff;
      best_in   = best_ff;
      bval_in   = bval_ff;
      cur_in    = cur_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      reb_in    = reb_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = ent_ff;
      rd_addr   = '0;
      done      = 1'b0;
      result    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in   = func;
               ent_in    = entry;
               status_in = ST_OK;
               fpos_in   = '0;
               fpri_in   = '0;
               min_in    = '0;
               idx_in    = '0;
               found_in  = 1'b0;
               unique case (func)
                  FN_INSERT: begin
                     if (cnt_ff >= CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_TOP_RD;
                     end else begin
                        state_in = S_INS;
                     end
                  end
                  FN_REMOVE: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_TOP_RD;
                     end else begin
                        state_in = S_RM_RD;
                     end
                  end
                  FN_CHANGE, FN_MIN: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_TOP_RD;
                     end else begin
                        state_in = S_SC_RD;
                     end
                  end
                  FN_LOOKUP: begin
                     status_in = ST_NOTFOUND;
                     state_in  = (cnt_ff == '0) ? S_TOP_RD : S_SC_RD;
                  end
                  default: state_in = S_TOP_RD;
               endcase
            end
         end
         S_INS: begin
            wr_en   = 1'b1;
            wr_addr = AW'(cnt_ff);
            wr_data = ent_ff;
            cnt_in  = cnt_ff + CW'(1);
            reb_in  = 1'b1;
            p_in    = '0;
            t_in    = (CW+1)'(2);
            state_in = (cnt_ff == '0) ? S_TOP_RD : S_PCALC;
         end
         S_PCALC: begin
            if ((t_ff + (CW+1)'(3)) <= {1'b0, cnt_ff}) begin
               p_in = p_ff + AW'(1);
               t_in = t_ff + (CW+1)'(3);
            end else begin
               si_in    = p_ff;
               state_in = S_SD_RD;
            end
         end
         S_SD_RD: begin
            rd_addr  = si_ff;
            state_in = S_SD_LD;
         end
         S_SD_LD: begin
            cur_in   = rd_data;
            bval_in  = rd_data;
            best_in  = si_ff;
            k_in     = '0;
            state_in = S_SD_CH;
         end
         S_SD_CH: begin
            if (child < CHW'(cnt_ff)) begin
               rd_addr  = child[AW-1:0];
               c_in     = child[AW-1:0];
               state_in = S_SD_CMP;
            end else if (k_ff == 2'd2) begin
               state_in = S_SWAP0;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_SD_CMP: begin
            if (rd_data.pri > bval_ff.pri) begin
               best_in = c_ff;
               bval_in = rd_data;
            end
            if (k_ff == 2'd2) begin
               state_in = S_SWAP0;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_SD_CH;
            end
         end
         S_SWAP0: begin
            if (best_ff == si_ff) begin
               if (reb_ff && (p_ff != '0)) begin
                  p_in     = p_ff - AW'(1);
                  si_in    = p_ff - AW'(1);
                  state_in = S_SD_RD;
               end else begin
                  state_in = S_TOP_RD;
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = si_ff;
               wr_data  = bval_ff;
               state_in = S_SWAP1;
            end
         end
         S_SWAP1: begin
            wr_en    = 1'b1;
            wr_addr  = best_ff;
            wr_data  = cur_ff;
            si_in    = best_ff;
            bval_in  = cur_ff;
            k_in     = '0;
            state_in = S_SD_CH;
         end
         S_RM_RD: begin
            rd_addr  = AW'(cnt_ff - CW'(1));
            state_in = S_RM_WR;
         end
         S_RM_WR: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = rd_data;
            cnt_in   = cnt_ff - CW'(1);
            si_in    = '0;
            reb_in   = 1'b0;
            state_in = S_SD_RD;
         end
         S_SC_RD: begin
            rd_addr  = idx_ff;
            state_in = S_SC_CMP;
         end
         S_SC_CMP: begin
            state_in = S_SC_RD;
            idx_in   = idx_ff + AW'(1);
            unique case (func_ff)
               FN_CHANGE: begin
                  if (rd_data.key == ent_ff.key) begin
                     hit_in   = idx_ff;
                     found_in = 1'b1;
                  end
                  if (scan_last) begin
                     if (found_ff || (rd_data.key == ent_ff.key)) begin
                        state_in = S_CP_RD;
                     end else begin
                        status_in = ST_NOTFOUND;
                        state_in  = S_TOP_RD;
                     end
                  end
               end
               FN_LOOKUP: begin
                  if (rd_data.key == ent_ff.key) begin
                     status_in = ST_OK;
                     fpos_in   = 8'(CW'(idx_ff) + CW'(1));
                     fpri_in   = rd_data.pri;
                     state_in  = S_TOP_RD;
                  end else if (scan_last) begin
                     state_in = S_TOP_RD;
                  end
               end
               FN_MIN: begin
                  if ((idx_ff == '0) || (rd_data.pri < min_ff.pri)) begin
                     min_in = rd_data;
                  end
                  if (scan_last) begin
                     state_in = S_TOP_RD;
                  end
               end
               default: state_in = S_TOP_RD;
            endcase
         end
         S_CP_RD: begin
            rd_addr  = AW'(cnt_ff - CW'(1));
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            wr_en    = 1'b1;
            wr_addr  = hit_ff;
            wr_data  = rd_data;
            cnt_in   = cnt_ff - CW'(1);
            state_in = S_INS;
         end
         S_TOP_RD: begin
            rd_addr  = '0;
            state_in = S_FIN;
         end
         S_FIN: begin
            result.status         = status_ff;
            result.count          = 8'(cnt_ff);
            result.top_key        = (cnt_ff != '0) ? rd_data.key : '0;
            result.top_priority   = (cnt_ff != '0) ? rd_data.pri : '0;
            result.found_position = fpos_ff;
            result.found_priority = fpri_ff;
            result.min_key        = min_ff.key;
            result.min_priority   = min_ff.pri;
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      func_ff   <= func_in;
      ent_ff    <= ent_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      fpos_ff   <= fpos_in;
      fpri_ff   <= fpri_in;
      min_ff    <= min_in;
      p_ff      <= p_in;
      t_ff      <= t_in;
      si_ff     <= si_in;
      best_ff   <= best_in;
      bval_ff   <= bval_in;
      cur_ff    <= cur_in;
      c_ff      <= c_in;
      k_ff      <= k_in;
      reb_ff    <= reb_in;
   end

endmodule
`default_nettype wire

// File: rtl/ternary_max_heap_queue_core.sv
`default_nettype none
// Three-way max-heap priority queue of up to CAPACITY entries (16-bit key, 8-bit priority),
// one result beat per request beat. A single sequencer drives a store with one write port and
// one registered read port, so each item is a series of one-access steps and the block takes no
// new request until the current one has finished. Lookup, find-minimum and change-priority scan
// the entries one at a time, with a read step and a compare step each; remove-top sifts one
// path down; insert searches the first parent and then sifts every parent back to the root;
// every item ends by fetching the root for the reply. The store needs no clearing after reset.
module ternary_max_heap_queue_core
   import tmhq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // entry_key, new_priority
   input  wire logic [2:0]  req_tuser,  // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // count, top_key, top_priority, found_position,
                                        // found_priority, min_key, min_priority
   output logic [1:0]       rsp_tuser   // status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   entry_type     req_entry;
   logic          seq_idle;
   logic          seq_done;
   result_type    seq_result;
   logic          out_free;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign req_entry     = {req_tdata[15:0], req_tdata[23:16]};
   assign req_tready    = seq_idle;
   assign out_free      = !rsp_valid_ff || rsp_tready;

   tmhq_seq #(
      .CAPACITY(CAPACITY),
      .AW(AW),
      .CW(CW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .start(req_tvalid && req_tready),
      .func(req_tuser),
      .entry(req_entry),
      .idle(seq_idle),
      .out_free(out_free),
      .done(seq_done),
      .result(seq_result),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   tmhq_store #(
      .DEPTH(CAPACITY),
      .AW(AW)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = seq_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {rsp_ff.min_priority, rsp_ff.min_key, rsp_ff.found_priority,
                        rsp_ff.found_position, rsp_ff.top_priority, rsp_ff.top_key,
                        rsp_ff.count};

`include "ternary_max_heap_queue_core_assert.svh"

   `TMHQ_ASSERT_NXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `TMHQ_ASSERT_IMP(a_empty_count, clock, reset, rsp_tvalid && (rsp_tuser == ST_EMPTY),
      rsp_ff.count == 8'd0)
   `TMHQ_ASSERT_IMP(a_empty_top, clock, reset, rsp_tvalid && (rsp_tuser == ST_EMPTY),
      (rsp_ff.top_key == 16'd0) && (rsp_ff.top_priority == 8'd0))

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
module tb_top;
   import tmhq_pkg::*;

   localparam int CAP = CAPACITY_DEF;
   localparam longint MAX_CYCLES = 64'd6000000;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  count;
      logic [15:0] top_key;
      logic [7:0]  top_priority;
      logic [7:0]  found_position;
      logic [7:0]  found_priority;
      logic [15:0] min_key;
      logic [7:0]  min_priority;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   ternary_max_heap_queue_core #(.CAPACITY(CAP)) dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [15:0] hp_key [CAP];
   logic [7:0]  hp_pri [CAP];
   int          hp_count;
   reply_type   pending_replies [$];
   int          errors = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   longint      cycle_count = 0;

   function automatic void hp_swap(int a, int b);
      logic [15:0] k;
      logic [7:0]  p;
      k = hp_key[a]; p = hp_pri[a];
      hp_key[a] = hp_key[b]; hp_pri[a] = hp_pri[b];
      hp_key[b] = k; hp_pri[b] = p;
   endfunction

   function automatic void hp_sift_down(int n, int start);
      int i, best, c;
      i = start;
      forever begin
         best = i;
         for (int j = 3; j >= 1; j--) begin
            c = 3 * i + j;
            if (c < n && hp_pri[c] > hp_pri[best]) best = c;
         end
         if (best == i) return;
         hp_swap(i, best);
         i = best;
      end
   endfunction

   function automatic void hp_push(logic [15:0] k, logic [7:0] p);
      hp_key[hp_count] = k;
      hp_pri[hp_count] = p;
      hp_count++;
      if (hp_count >= 2)
         for (int q = (hp_count - 2) / 3; q >= 0; q--) hp_sift_down(hp_count, q);
   endfunction

   function automatic reply_type heap_apply(logic [2:0] fn, logic [15:0] k, logic [7:0] p);
      reply_type r;
      int hit, m;
      r = '0;
      r.status = ST_OK;
      case (fn)
         FN_INSERT: begin
            if (hp_count >= CAP) r.status = ST_FULL;
            else hp_push(k, p);
         end
         FN_REMOVE: begin
            if (hp_count == 0) r.status = ST_EMPTY;
            else begin
               hp_key[0] = hp_key[hp_count - 1]; hp_pri[0] = hp_pri[hp_count - 1];
               hp_count--;
               hp_sift_down(hp_count, 0);
            end
         end
         FN_CHANGE: begin
            if (hp_count == 0) r.status = ST_EMPTY;
            else begin
               hit = -1;
               for (int i = 0; i < hp_count; i++) if (hp_key[i] == k) hit = i;
               if (hit < 0) r.status = ST_NOTFOUND;
               else begin
                  hp_key[hit] = hp_key[hp_count - 1]; hp_pri[hit] = hp_pri[hp_count - 1];
                  hp_count--;
                  hp_push(k, p);
               end
            end
         end
         FN_LOOKUP: begin
            r.status = ST_NOTFOUND;
            for (int i = 0; i < hp_count; i++)
               if (hp_key[i] == k) begin
                  r.status = ST_OK;
                  r.found_position = 8'(i + 1);
                  r.found_priority = hp_pri[i];
                  break;
               end
         end
         FN_MIN: begin
            if (hp_count == 0) r.status = ST_EMPTY;
            else begin
               m = 0;
               for (int i = 1; i < hp_count; i++) if (hp_pri[i] < hp_pri[m]) m = i;
               r.min_key = hp_key[m];
               r.min_priority = hp_pri[m];
            end
         end
         default: ;
      endcase
      r.count = 8'(hp_count);
      if (hp_count > 0) begin
         r.top_key = hp_key[0];
         r.top_priority = hp_pri[0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
      errors++;
   endtask

   task automatic send_op(logic [2:0] fn, logic [15:0] k, logic [7:0] p);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      pending_replies.push_back(heap_apply(fn, k, p));
      req_tvalid <= 1'b1;
      req_tdata <= {p, k};
      req_tuser <= fn;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver stall
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      reply_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '0;
         got.status = rsp_tuser;
         {got.min_priority, got.min_key, got.found_priority, got.found_position,
          got.top_priority, got.top_key, got.count} = rsp_tdata;
         if (pending_replies.size() == 0) begin
            $display("unexpected beat at cycle %0d", cycle_count);
            errors++;
         end else begin
            want = pending_replies.pop_front();
            if (got.status != want.status) report_mismatch("status", got.status, want.status);
            if (got.count != want.count) report_mismatch("count", got.count, want.count);
            if (got.top_key != want.top_key) report_mismatch("top_key", got.top_key, want.top_key);
            if (got.top_priority != want.top_priority)
               report_mismatch("top_priority", got.top_priority, want.top_priority);
            if (got.found_position != want.found_position)
               report_mismatch("found_position", got.found_position, want.found_position);
            if (got.found_priority != want.found_priority)
               report_mismatch("found_priority", got.found_priority, want.found_priority);
            if (got.min_key != want.min_key) report_mismatch("min_key", got.min_key, want.min_key);
            if (got.min_priority != want.min_priority)
               report_mismatch("min_priority", got.min_priority, want.min_priority);
         end
      end
      if (cycle_count > MAX_CYCLES) begin
         $display("tb_top failed");
         $finish;
      end
   end

   function automatic logic [15:0] pick_key();
      if (hp_count > 0 && $urandom_range(3) != 0) return hp_key[$urandom_range(hp_count - 1)];
      return 16'($urandom_range(15));
   endfunction

   task automatic test_directed();
      send_op(FN_REMOVE, 16'h0, 8'h0);
      send_op(FN_MIN, 16'h0, 8'h0);
      send_op(FN_CHANGE, 16'h1, 8'h5);
      send_op(FN_LOOKUP, 16'hFFFF, 8'h0);
      send_op(FN_INSERT, 16'hFFFF, 8'hFF);
      send_op(FN_INSERT, 16'h0000, 8'h00);
      send_op(FN_INSERT, 16'h1234, 8'h80);
      send_op(FN_INSERT, 16'h5555, 8'h80);
      send_op(FN_INSERT, 16'hAAAA, 8'h80);
      send_op(FN_INSERT, 16'h1234, 8'h7F);
      send_op(FN_LOOKUP, 16'h1234, 8'h0);
      send_op(FN_LOOKUP, 16'h7777, 8'h0);
      send_op(FN_CHANGE, 16'h1234, 8'hFF);
      send_op(FN_CHANGE, 16'h9999, 8'h01);
      send_op(FN_MIN, 16'h0, 8'h0);
      send_op(3'd5, 16'hFFFF, 8'hFF);
      send_op(3'd6, 16'h0, 8'h0);
      send_op(3'd7, 16'h1, 8'h1);
      send_op(FN_REMOVE, 16'h0, 8'h0);
      send_op(FN_REMOVE, 16'h0, 8'h0);
   endtask

   task automatic test_fill_to_full();
      while (hp_count < CAP)
         send_op(FN_INSERT, 16'($urandom), 8'($urandom_range(3) * 85));
      send_op(FN_INSERT, 16'hFFFF, 8'hFF);
      send_op(FN_MIN, 16'h0, 8'h0);
      send_op(FN_LOOKUP, hp_key[CAP - 1], 8'h0);
      while (hp_count > 0) send_op(FN_REMOVE, 16'h0, 8'h0);
      send_op(FN_REMOVE, 16'h0, 8'h0);
   endtask

   task automatic test_random(int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 35)
            send_op(FN_INSERT, pick_key(),
                    8'($urandom_range(0, 7) * 36 + $urandom_range(3)));
         else if (sel < 55) send_op(FN_REMOVE, 16'($urandom), 8'($urandom));
         else if (sel < 70) send_op(FN_CHANGE, pick_key(), 8'($urandom));
         else if (sel < 85) send_op(FN_LOOKUP, pick_key(), 8'($urandom));
         else if (sel < 97) send_op(FN_MIN, 16'($urandom), 8'($urandom));
         else send_op(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 10; recv_idle_pct = 60;
      test_directed();
      test_random(80);
      send_idle_pct = 60; recv_idle_pct = 10;
      test_fill_to_full();
      test_random(80);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(80);
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (errors == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end
endmodule
`default_nettype wire
